// ----- src/fla_pkg.sv -----
// ----------------------------------------------------------------------------
// Flux-limited advection package
// Shared constants, codes and types for the advection column block.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int MaxCellsDefault     = 256;
  localparam int FractionBitsDefault = 16;

  localparam logic [1:0] LIM_UPWIND   = 2'd0;
  localparam logic [1:0] LIM_LAX      = 2'd1;
  localparam logic [1:0] LIM_BEAM     = 2'd2;
  localparam logic [1:0] LIM_SUPERBEE = 2'd3;

  localparam logic [1:0] REG_FLOW    = 2'd0;
  localparam logic [1:0] REG_LIMITER = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;

  // Operation codes of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV
  } fla_op_t;

  typedef struct packed {
    logic    start;
    fla_op_t op;
  } fla_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fla_sts_t;

endpackage

// ----- src/fla_alu.sv -----
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Bit-serial unsigned 64x64 multiply and 64-bit by 64-bit restoring divide,
// one bit a cycle.
// ----------------------------------------------------------------------------
module fla_alu (
  input  logic              clk,
  input  logic              rst,
  input  fla_pkg::fla_ctl_t ctl,
  input  logic [63:0]       opa,
  input  logic [63:0]       opb,
  output fla_pkg::fla_sts_t sts,
  output logic [127:0]      result
);
  import fla_pkg::*;

  logic          busy;
  fla_op_t       op;
  logic [6:0]    count;
  logic [127:0]  acc;
  logic [63:0]   operand;
  logic [64:0]   rem_try;
  logic          done;

  assign rem_try = {acc[127:63]} - {1'b0, operand};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy    <= 1'b1;
        op      <= ctl.op;
        count   <= '0;
        operand <= opb;
        if (ctl.op == OP_DIV) begin
          acc <= {64'd0, opa};
        end else begin
          acc <= {64'd0, opa};
        end
      end else if (busy) begin
        if (op == OP_DIV) begin
          // Restoring step: remainder in the upper half, quotient shifts in below.
          if (!rem_try[64]) begin
            acc <= {rem_try[63:0], acc[62:0], 1'b1};
          end else begin
            acc <= {acc[126:0], 1'b0};
          end
        end else begin
          // Shift-add: the upper half accumulates, the multiplier drains below.
          acc <= acc[0] ? {{1'b0, acc[127:64]} + {1'b0, operand}, acc[63:1]}
                        : {1'b0, acc[127:1]};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    result = acc;
    if (op == OP_MUL) begin
      result = acc;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- src/flux_limited_advection_column.sv -----
// ----------------------------------------------------------------------------
// Flux-limited advection column
// Computes the limited advective flux at every face of one axial column.
// ----------------------------------------------------------------------------
// Cells of a column enter in flow order, one request at a time; each request
// yields one face flux, two on the last cell. A face takes seven passes
// through one shared bit-serial multiply/divide unit (theta division, Courant
// product and division, three limiter products, advective product), each a
// start, one serial step per operand bit and a done. Besides the passes, a
// face goes through the setup, limiter, sum and output states; the theta
// division is skipped when the local difference is zero, and the last cell
// runs the face sequence twice. Output stalls hold the block in S_OUT.
// Input ready is low while a cell is processed.
module flux_limited_advection_column #(
  parameter int MAX_CELLS     = fla_pkg::MaxCellsDefault,
  parameter int FRACTION_BITS = fla_pkg::FractionBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] concentration,
  input  logic signed [31:0] velocity,
  input  logic [30:0]        cell_height,
  input  logic signed [31:0] inlet_conc_first,
  input  logic signed [31:0] inlet_conc_second,
  input  logic signed [31:0] inlet_velocity,
  input  logic signed [31:0] outlet_conc,
  input  logic               first_cell,
  input  logic               last_cell,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] face_flux,
  output logic [8:0]         face_index,
  output logic               column_done
);
  import fla_pkg::*;

  localparam int CntW = $clog2(MAX_CELLS + 1);
  localparam logic signed [63:0] OneQ = 64'sd1 <<< FRACTION_BITS;
  localparam logic [63:0] BigMag = 64'd1 << 62;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_THETA, S_PHI, S_DIRAC, S_CMUL, S_CDIV,
    S_KMUL, S_CORR, S_ADV, S_SUM, S_OUT
  } state_t;

  state_t state;
  logic flow_positive;
  logic [1:0] limiter_mode;
  logic [30:0] time_step;

  logic signed [31:0] prior_conc0, prior_conc1, prior_velocity;
  logic [30:0] prior_height;
  logic signed [31:0] latched_outlet;
  logic [CntW-1:0] cell_counter;

  logic signed [31:0] cur_c, cur_v;
  logic [30:0] cur_h;
  logic cur_last, second_face;

  // Operands of the face under work.
  logic signed [63:0] f_v, f_cup, f_dc, f_up;
  logic [30:0] f_h;
  logic [CntW-1:0] f_idx;

  logic signed [63:0] theta, phi, dirac, k_val, corr;
  logic [63:0] courant;

  fla_ctl_t ctl;
  fla_sts_t sts;
  logic [63:0] opa, opb;
  logic [127:0] alu_res;
  logic issued;

  fla_alu u_alu (
    .clk(clk), .rst(rst), .ctl(ctl), .opa(opa), .opb(opb),
    .sts(sts), .result(alu_res)
  );

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    mag64 = a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Shift a 128-bit magnitude product and clamp to 2^62, then apply sign.
  function automatic logic signed [63:0] scale(input logic [127:0] p,
                                                input int sh, input logic neg);
    logic [127:0] s;
    logic [63:0] r;
    s = p >> sh;
    r = (s[127:63] != '0 || s[62:0] > BigMag[62:0]) ? BigMag : s[63:0];
    scale = neg ? -$signed(r) : $signed(r);
  endfunction

  logic signed [63:0] dc_eff, up_eff;
  assign dc_eff = flow_positive ? f_dc : -f_dc;
  assign up_eff = flow_positive ? f_up : -f_up;

  logic signed [63:0] m1, m2, sb, theta2;
  assign theta2 = theta <<< 1;
  assign m1 = theta2 < OneQ ? theta2 : OneQ;
  assign m2 = theta < (OneQ <<< 1) ? theta : (OneQ <<< 1);
  assign sb = (m1 > m2) ? m1 : m2;

  logic signed [63:0] onem, flux_sum;
  logic signed [47:0] flux_sat;
  logic signed [63:0] alu_res_adv;
  assign onem = OneQ - $signed(courant);
  assign alu_res_adv = scale(alu_res, FRACTION_BITS, f_v[63] != f_cup[63]);
  assign flux_sum = alu_res_adv + corr;
  assign flux_sat = (flux_sum > 64'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                    (flux_sum < -64'sh8000_0000_0000) ? 48'sh8000_0000_0000 :
                    flux_sum[47:0];

  logic [CntW-1:0] idx_next;
  assign idx_next = (f_idx < CntW'(MAX_CELLS)) ? f_idx + 1'b1 : CntW'(MAX_CELLS);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl.start = 1'b0;
    ctl.op = OP_MUL;
    opa = '0;
    opb = '0;
    if (!issued && !sts.busy && !sts.done) begin
      unique case (state)
        S_THETA: begin
          ctl.start = (dc_eff != 0);
          ctl.op = OP_DIV;
          opa = mag64(up_eff) << FRACTION_BITS;
          opb = mag64(dc_eff);
        end
        S_DIRAC: begin
          ctl.start = 1'b1;
          opa = mag64(phi);
          opb = mag64(dc_eff);
        end
        S_CMUL: begin
          ctl.start = 1'b1;
          opa = mag64(f_v);
          opb = {33'd0, time_step};
        end
        S_CDIV: begin
          ctl.start = 1'b1;
          ctl.op = OP_DIV;
          opa = courant;
          opb = (f_h == '0) ? 64'd1 : {33'd0, f_h};
        end
        S_KMUL: begin
          ctl.start = 1'b1;
          opa = mag64(f_v);
          opb = mag64(onem);
        end
        S_CORR: begin
          ctl.start = 1'b1;
          opa = mag64(k_val);
          opb = mag64(dirac);
        end
        S_ADV: begin
          ctl.start = 1'b1;
          opa = mag64(f_v);
          opb = mag64(f_cup);
        end
        default: begin
          ctl.start = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      flow_positive  <= 1'b1;
      limiter_mode   <= LIM_SUPERBEE;
      time_step      <= 31'd65536;
      prior_conc0    <= '0;
      prior_conc1    <= '0;
      prior_velocity <= '0;
      prior_height   <= '0;
      latched_outlet <= '0;
      cell_counter   <= '0;
      out_valid      <= 1'b0;
      issued         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FLOW:    flow_positive <= cfg_data[0];
          REG_LIMITER: limiter_mode <= cfg_data[1:0];
          REG_STEP:    time_step <= cfg_data;
          default:     ;
        endcase
      end
      if (ctl.start) begin
        issued <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_c <= concentration;
            cur_v <= velocity;
            cur_h <= cell_height;
            cur_last <= last_cell;
            second_face <= 1'b0;
            f_v <= 64'(concentration) - 64'(concentration) +
                   (first_cell ? 64'(inlet_velocity) : 64'(prior_velocity));
            f_h <= first_cell ? cell_height : prior_height;
            if (first_cell) begin
              latched_outlet <= outlet_conc;
              prior_conc0 <= flow_positive ? inlet_conc_second : inlet_conc_first;
              prior_conc1 <= flow_positive ? inlet_conc_first : inlet_conc_second;
              f_cup <= flow_positive ? 64'(inlet_conc_second) : 64'(inlet_conc_first);
              f_dc <= 64'(concentration) -
                      (flow_positive ? 64'(inlet_conc_second) : 64'(inlet_conc_first));
              f_up <= flow_positive ? 64'(inlet_conc_second) - 64'(inlet_conc_first)
                                    : 64'(inlet_conc_first) - 64'(inlet_conc_second);
              f_idx <= '0;
              cell_counter <= '0;
            end else begin
              f_cup <= 64'(prior_conc0);
              f_dc <= 64'(concentration) - 64'(prior_conc0);
              f_up <= 64'(prior_conc0) - 64'(prior_conc1);
              f_idx <= cell_counter;
            end
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state <= S_THETA;
        end
        S_THETA: begin
          if (dc_eff == 0 && !issued) begin
            theta <= OneQ;
            state <= S_PHI;
          end else if (sts.done) begin
            issued <= 1'b0;
            if (up_eff[63] != dc_eff[63]) begin
              theta <= (alu_res[63:0] > 64'h8000_0000) ? -64'sh8000_0000
                                                       : -$signed(alu_res[63:0]);
            end else begin
              theta <= (alu_res[63:0] > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF
                                                       : $signed(alu_res[63:0]);
            end
            state <= S_PHI;
          end
        end
        S_PHI: begin
          unique case (limiter_mode)
            LIM_UPWIND:   phi <= '0;
            LIM_LAX:      phi <= OneQ;
            LIM_BEAM:     phi <= theta;
            LIM_SUPERBEE: phi <= sb[63] ? '0 : sb;
            default:      phi <= '0;
          endcase
          state <= S_DIRAC;
        end
        S_DIRAC: begin
          if (sts.done) begin
            issued <= 1'b0;
            dirac <= scale(alu_res, FRACTION_BITS, (phi[63] != dc_eff[63]) &&
                           phi != 0 && dc_eff != 0);
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          if (sts.done) begin
            issued <= 1'b0;
            courant <= alu_res[63:0];
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (sts.done) begin
            issued <= 1'b0;
            courant <= (alu_res[63:0] > 64'h1_0000_0000) ? 64'h1_0000_0000
                                                         : alu_res[63:0];
            state <= S_KMUL;
          end
        end
        S_KMUL: begin
          if (sts.done) begin
            issued <= 1'b0;
            k_val <= scale(alu_res, FRACTION_BITS + 1, onem[63] && f_v != 0);
            state <= S_CORR;
          end
        end
        S_CORR: begin
          if (sts.done) begin
            issued <= 1'b0;
            corr <= scale(alu_res, FRACTION_BITS, (k_val[63] != dirac[63]) &&
                          k_val != 0 && dirac != 0);
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (sts.done) begin
            issued <= 1'b0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          face_flux <= flux_sat;
          face_index <= 9'(f_idx);
          column_done <= second_face;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (cur_last && !second_face) begin
              second_face <= 1'b1;
              f_v <= 64'(cur_v);
              f_cup <= 64'(cur_c);
              f_h <= cur_h;
              f_dc <= 64'(latched_outlet) - 64'(cur_c);
              f_up <= f_dc;
              f_idx <= (f_idx < CntW'(MAX_CELLS)) ? f_idx + 1'b1 : CntW'(MAX_CELLS);
              state <= S_SETUP;
            end else begin
              // The upstream value of the cell's own face becomes the older history.
              prior_conc1 <= prior_conc0;
              prior_conc0 <= cur_c;
              prior_velocity <= cur_v;
              prior_height <= cur_h;
              cell_counter <= cur_last ? '0 : idx_next;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/flux_limited_advection_column_test.sv -----
// ----------------------------------------------------------------------------
// Flux-limited advection column testbench
// Streams columns of cells through the block under every limiter, both flow
// directions and extreme time steps, predicts each face flux in the bench and
// compares the returned faces in order, with random idling and a long
// receiver stall.
// ----------------------------------------------------------------------------
module flux_limited_advection_column_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fla_pkg::*;

  typedef struct {
    logic signed [31:0] conc;
    logic signed [31:0] vel;
    logic [30:0]        height;
    logic signed [31:0] inlet_first;
    logic signed [31:0] inlet_second;
    logic signed [31:0] inlet_vel;
    logic signed [31:0] outlet;
    logic               first;
    logic               last;
  } cell_t;

  typedef struct {
    logic signed [47:0] flux;
    logic [8:0]         index;
    logic               done;
  } face_t;

  localparam longint OneQ = 64'sd65536;
  localparam logic [63:0] BigMag = 64'd1 << 62;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_FLOW;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] concentration = '0, velocity = '0;
  logic [30:0] cell_height = '0;
  logic signed [31:0] inlet_conc_first = '0, inlet_conc_second = '0;
  logic signed [31:0] inlet_velocity = '0, outlet_conc = '0;
  logic first_cell = 1'b0, last_cell = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] face_flux;
  logic [8:0] face_index;
  logic column_done;

  flux_limited_advection_column dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cell_t  pending_cells[$];
  face_t  expected_faces[$];
  int     errors = 0;
  int     cells_sent = 0;
  int     faces_seen = 0;
  bit     calm = 0;
  logic   hold_request = 1'b0;

  // Bench copy of the configuration and the column state.
  logic       flow_pos = 1'b1;
  logic [1:0] limiter = LIM_SUPERBEE;
  logic [63:0] dt = 64'd65536;
  longint     prev_conc[2] = '{0, 0};
  longint     prev_vel = 0;
  logic [63:0] prev_h = 0;
  longint     boundary[4] = '{0, 0, 0, 0};
  int         face_count = 0;

  function automatic logic [63:0] mag(longint a);
    return a < 0 ? 64'd0 - 64'(a) : 64'(a);
  endfunction

  // Product of magnitudes shifted right, clamped to 2^62, sign restored.
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [127:0] p;
    p = ({64'd0, mag(a)} * {64'd0, mag(b)}) >> sh;
    if (p > {64'd0, BigMag}) p = {64'd0, BigMag};
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [47:0] limited_flux(longint v, longint cup,
                                                     logic [63:0] h, longint dc,
                                                     longint up);
    longint theta, phi, m1, m2, onem, k, dirac, flux;
    logic [63:0] q, absv, courant;
    if (!flow_pos) begin
      dc = -dc;
      up = -up;
    end
    if (dc == 0) begin
      theta = OneQ;
    end else begin
      q = (mag(up) << 16) / mag(dc);
      if ((up < 0) != (dc < 0))
        theta = q > 64'h8000_0000 ? -longint'(64'h8000_0000) : -longint'(q);
      else
        theta = q > 64'h7fff_ffff ? longint'(64'h7fff_ffff) : longint'(q);
    end
    case (limiter)
      LIM_UPWIND: phi = 0;
      LIM_LAX:    phi = OneQ;
      LIM_BEAM:   phi = theta;
      default: begin
        m1 = 2 * theta < OneQ ? 2 * theta : OneQ;
        m2 = theta < 2 * OneQ ? theta : 2 * OneQ;
        phi = m1 > m2 ? m1 : m2;
        if (phi < 0) phi = 0;
      end
    endcase
    dirac = scaled_product(phi, dc, 16);
    absv = mag(v);
    courant = (absv * dt) / (h != 0 ? h : 64'd1);
    if (courant > (64'd1 << 32)) courant = 64'd1 << 32;
    onem = OneQ - longint'(courant);
    k = scaled_product(longint'(absv), onem, 17);
    flux = scaled_product(v, cup, 16) + scaled_product(k, dirac, 16);
    if (flux > (64'sd1 <<< 47) - 1) flux = (64'sd1 <<< 47) - 1;
    if (flux < -(64'sd1 <<< 47)) flux = -(64'sd1 <<< 47);
    return flux[47:0];
  endfunction

  task automatic predict_faces(cell_t c);
    longint cv, vv;
    logic [63:0] hv;
    face_t f;
    int nidx;
    cv = c.conc;
    vv = c.vel;
    hv = {33'd0, c.height};
    if (c.first) begin
      boundary[0] = c.inlet_first;
      boundary[1] = c.inlet_second;
      boundary[2] = c.inlet_vel;
      boundary[3] = c.outlet;
      prev_conc[0] = flow_pos ? boundary[1] : boundary[0];
      prev_conc[1] = flow_pos ? boundary[0] : boundary[1];
      prev_vel = boundary[2];
      prev_h = hv;
      face_count = 0;
    end
    f.flux = limited_flux(prev_vel, prev_conc[0], prev_h, cv - prev_conc[0],
                          prev_conc[0] - prev_conc[1]);
    f.index = face_count[8:0];
    f.done = 1'b0;
    expected_faces.push_back(f);
    nidx = face_count < 256 ? face_count + 1 : 256;
    if (c.last) begin
      f.flux = limited_flux(vv, cv, hv, boundary[3] - cv, cv - prev_conc[0]);
      f.index = nidx[8:0];
      f.done = 1'b1;
      expected_faces.push_back(f);
    end
    prev_conc[1] = prev_conc[0];
    prev_conc[0] = cv;
    prev_vel = vv;
    prev_h = hv;
    face_count = c.last ? 0 : nidx;
  endtask

  function automatic bit take_break();
    return !calm && $urandom_range(0, 99) < 7;
  endfunction

  // Sender: one request per accepted cell, fed from the pending queue.
  always @(posedge clk) begin
    cell_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_faces('{concentration, velocity, cell_height, inlet_conc_first,
                        inlet_conc_second, inlet_velocity, outlet_conc,
                        first_cell, last_cell});
        cells_sent++;
      end
      if (pending_cells.size() != 0 && !take_break()) begin
        c = pending_cells.pop_front();
        concentration <= c.conc;
        velocity <= c.vel;
        cell_height <= c.height;
        inlet_conc_first <= c.inlet_first;
        inlet_conc_second <= c.inlet_second;
        inlet_velocity <= c.inlet_vel;
        outlet_conc <= c.outlet;
        first_cell <= c.first;
        last_cell <= c.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each face against the oldest prediction.
  int  stall_left = 0;
  bit  stall_used = 0;
  always @(posedge clk) begin
    face_t f;
    if (!rst && out_valid && out_ready) begin
      faces_seen++;
      if (expected_faces.size() == 0) begin
        $display("%0t: unexpected face: flux %0d index %0d done %0b", $time,
                 face_flux, face_index, column_done);
        errors++;
      end else begin
        f = expected_faces.pop_front();
        if (f.flux !== face_flux || f.index !== face_index || f.done !== column_done) begin
          $display("%0t: face mismatch: expected flux %0d index %0d done %0b, got %0d %0d %0b",
                   $time, f.flux, f.index, f.done, face_flux, face_index, column_done);
          errors++;
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !stall_used) begin
      stall_used <= 1;
      stall_left <= 3000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("%0t: no progress, %0d faces outstanding", $time, expected_faces.size());
      $display("flux_limited_advection_column_test: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FLOW:    flow_pos = value[0];
      REG_LIMITER: limiter = value[1:0];
      default:     dt = {33'd0, value};
    endcase
  endtask

  task automatic settle();
    while (pending_cells.size() != 0 || in_valid || expected_faces.size() != 0)
      @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value(logic signed [31:0] near);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1, 2:    return $urandom;
      3:       return near;
      default: return near + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic logic [30:0] rand_height();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 31'h7fff_ffff;
      2, 3:    return 31'($urandom);
      default: return 31'($urandom_range(1 << 14, 1 << 20));
    endcase
  endfunction

  // One column of random content; broken columns drop or duplicate marks.
  task automatic add_column(int n, bit broken);
    cell_t c;
    logic signed [31:0] level, speed;
    level = rand_value(0);
    speed = rand_value(flow_pos ? 32'sh0001_0000 : -32'sh0001_0000);
    for (int i = 0; i < n; i++) begin
      level = rand_value(level);
      c.conc = level;
      c.vel = rand_value(speed);
      c.height = rand_height();
      c.inlet_first = rand_value(level);
      c.inlet_second = rand_value(level);
      c.inlet_vel = rand_value(speed);
      c.outlet = rand_value(level);
      c.first = (i == 0);
      c.last = (i == n - 1);
      if (broken) begin
        c.first = $urandom_range(0, 2) == 0;
        c.last = $urandom_range(0, 2) == 0;
      end
      pending_cells.push_back(c);
    end
  endtask

  initial begin
    cell_t c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: a column before any first mark, extremes, equal neighbors,
    // zero height and both marks on one cell, under the reset settings.
    c = '{32'sh0001_0000, 32'sh0001_0000, 31'h1_0000, 0, 0, 0, 0, 1'b0, 1'b0};
    pending_cells.push_back(c);
    c = '{32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff, 32'sh8000_0000,
          32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 1'b0};
    pending_cells.push_back(c);
    c = '{32'sh8000_0000, 32'sh8000_0000, 31'd1, 0, 0, 0, 0, 1'b0, 1'b0};
    pending_cells.push_back(c);
    c = '{32'sh8000_0000, 32'sh7fff_ffff, 31'd0, 0, 0, 0, 0, 1'b0, 1'b1};
    pending_cells.push_back(c);
    c = '{32'sh0002_0000, 32'sh0000_8000, 31'h2_0000, 32'sh0002_0000,
          32'sh0002_0000, 32'sh0000_8000, 32'sh0002_0000, 1'b1, 1'b0};
    pending_cells.push_back(c);
    c.first = 1'b0;
    pending_cells.push_back(c);
    c.last = 1'b1;
    pending_cells.push_back(c);
    c = '{32'sh0003_0000, -32'sh0001_0000, 31'h1_0000, 32'sh0001_0000,
          -32'sh0001_0000, 32'sh0004_0000, -32'sh0005_0000, 1'b1, 1'b1};
    pending_cells.push_back(c);
    for (int i = 0; i < 4; i++) add_column(3, 0);
    settle();

    // Random phases sweep every limiter, both directions and dt extremes.
    for (int phase = 0; phase < 12; phase++) begin
      write_reg(REG_FLOW, 31'(phase % 2));
      write_reg(REG_LIMITER, 31'(phase % 4));
      case (phase % 3)
        0:       write_reg(REG_STEP, 31'd1);
        1:       write_reg(REG_STEP, 31'h7fff_ffff);
        default: write_reg(REG_STEP, 31'($urandom_range(1 << 12, 1 << 18)));
      endcase
      calm = (phase == 5);
      if (phase == 3) add_column(258, 0);
      while (pending_cells.size() < 150) begin
        if ($urandom_range(0, 9) == 0) add_column($urandom_range(1, 6), 1);
        else add_column($urandom_range(1, 8), 0);
      end
      if (phase == 7) hold_request <= 1'b1;
      settle();
    end
    calm = 0;

    $display("Sent %0d cells in %0d settings (all limiters, both flow directions,",
             cells_sent, 13);
    $display("  extreme time steps, broken and overlong columns); %0d faces checked.",
             faces_seen);
    if (errors == 0)
      $display("flux_limited_advection_column_test: done, clean");
    else
      $display("flux_limited_advection_column_test: done, errors");
    $finish;
  end
endmodule

// ----- flux_limited_advection_column.f -----
src/fla_pkg.sv
src/fla_alu.sv
src/flux_limited_advection_column.sv
sim/flux_limited_advection_column_test.sv
